// ===== sv/bfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bfr_pkg: shared definitions for the bytecode frame receiver
// Store geometry, CRC constants, protocol codes and result codes.
// ----------------------------------------------------------------------------
package bfr_pkg;

  // Byte store geometry.
  localparam int unsigned STORE_BYTES = 4096;
  localparam int unsigned STORE_AW    = $clog2(STORE_BYTES);

  // Reflected CRC16.
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hD175;

  // Header codes.
  localparam logic [7:0] HDR_VERSION = 8'h01;
  localparam logic [7:0] CMD_DATA    = 8'h44;  // 'D'
  localparam logic [7:0] CMD_PROGRAM = 8'h50;  // 'P'
  localparam logic [7:0] CMD_REBOOT  = 8'h52;  // 'R'
  localparam logic [7:0] CMD_RESTART = 8'h4C;  // 'L'

  // Header lengths.
  localparam logic [16:0] DATA_HDR_LEN = 17'd6;
  localparam logic [16:0] PROG_LEN     = 17'd8;
  localparam logic [16:0] MIN_LEN      = 17'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SIZE      = 3'd1,
    ST_VERSION   = 3'd2,
    ST_DATA_SIZE = 3'd3,
    ST_OVER      = 3'd4,
    ST_BAD_SLOT  = 3'd5,
    ST_CRC       = 3'd6,
    ST_UNKNOWN   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_STORE   = 2'd1,
    ACT_REBOOT  = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

endpackage

// ===== sv/bfr_store.sv =====
// ----------------------------------------------------------------------------
// bfr_store: payload byte store
// Single-port byte memory with registered read data (read before write).
// ----------------------------------------------------------------------------
module bfr_store
  import bfr_pkg::*;
(
  input  logic                clk,
  input  logic                we,
  input  logic [STORE_AW-1:0] addr,
  input  logic [7:0]          wdata,
  output logic [7:0]          rdata
);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bfr_crc.sv =====
// ----------------------------------------------------------------------------
// bfr_crc: shared CRC16 unit
// Folds one byte per enabled cycle into a reflected CRC16 register.
// ----------------------------------------------------------------------------
module bfr_crc
  import bfr_pkg::*;
(
  input  logic        clk,
  input  logic        init,
  input  logic        en,
  input  logic [7:0]  data,
  output logic [15:0] crc
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  // Eight shift steps of the reflected CRC over one byte.
  always_comb begin
    crc_nxt = crc_r ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc_nxt[0]) begin
        crc_nxt = (crc_nxt >> 1) ^ CRC_POLY;
      end else begin
        crc_nxt = crc_nxt >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      crc_r <= CRC_SEED;
    end else if (en) begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

// ===== sv/bytecode_frame_receiver_crc16_top.sv =====
// ----------------------------------------------------------------------------
// bytecode_frame_receiver_crc16_top: bytecode loader frame receiver
// Checks frames, loads data payloads into a byte store and verifies programs
// by CRC16 before requesting that they be stored.
// ----------------------------------------------------------------------------
// The receiver takes one frame byte per cycle while in_tready is high and
// returns one result request after the final byte of each frame. Data ('D')
// frames write their payload into a 4096-byte store as the bytes arrive. A
// program ('P') frame of valid length that is within the store bound starts
// a sweep of the whole store: one address per cycle, each byte read out into
// the shared CRC16 unit (for the first program_length bytes, if the slot is
// valid) and written back to zero in the same cycle. During the sweep and
// S_TAIL the input is not ready, and a sweep that checks a CRC also passes
// S_DONE before the result is shown; the single store port causes this. After
// reset the same sweep clears the store with in_tready low; configuration
// writes are taken at any time. All other bytes are accepted back to back,
// one per cycle, as long as no earlier result waits unaccepted at the output;
// while one waits with out_tready low, no byte is taken.
// ----------------------------------------------------------------------------
module bytecode_frame_receiver_crc16_top
  import bfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: highest valid slot number.
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // Input requests: frame bytes.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] frame_byte, [24:8] frame_length, rest zero
  input  logic        in_tlast,   // last_byte
  // Result requests.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [2:0] status, [4:3] action, [12:5] slot_number,
                                  // [28:13] program_length, [44:29] computed_crc,
                                  // rest zero
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_TAIL,
    S_DONE,
    S_IDLE
  } state_t;

  state_t              state_r;
  logic [STORE_AW-1:0] addr_r;
  logic [16:0]         pos_r;
  logic [63:0]         hdr_r;
  status_t             ferr_r;
  logic [7:0]          slot_count_r;
  logic                do_crc_r;
  logic                rd_use_r;
  logic [15:0]         plen_r;
  logic [7:0]          slot_r;
  logic [15:0]         crc_ref_r;

  logic                out_valid_r;
  status_t             out_status_r;
  action_t             out_action_r;
  logic [7:0]          out_slot_r;
  logic [15:0]         out_plen_r;
  logic [15:0]         out_crc_r;

  logic [7:0]  in_byte;
  logic [16:0] in_len;
  logic        accept;
  logic        out_load;
  logic [63:0] hdr_cur;
  logic [15:0] h_off;
  logic [15:0] h_size;
  logic [15:0] h_plen;
  logic [15:0] h_crc;
  logic [7:0]  h_slot;
  logic [16:0] k_idx;
  logic [17:0] wr_idx;
  logic        wr_ok;

  logic        mem_we;
  logic [STORE_AW-1:0] mem_addr;
  logic [7:0]  mem_wdata;
  logic [7:0]  mem_rdata;
  logic [15:0] crc_val;
  logic        crc_init;

  status_t     res_status;
  action_t     res_action;
  logic [7:0]  res_slot;
  logic [15:0] res_plen;
  logic        res_sweep;
  logic        res_run_crc;

  assign in_byte = in_tdata[7:0];
  assign in_len  = in_tdata[24:8];
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept  = in_tvalid && in_tready;

  // Header as it stands once the current byte is merged in.
  always_comb begin
    hdr_cur = hdr_r;
    for (int i = 0; i < 8; i++) begin
      if (pos_r == 17'(i)) begin
        hdr_cur[8*i +: 8] = in_byte;
      end
    end
  end

  assign h_off  = hdr_cur[31:16];
  assign h_size = hdr_cur[47:32];
  assign h_plen = hdr_cur[31:16];
  assign h_crc  = hdr_cur[47:32];
  assign h_slot = hdr_cur[55:48];

  // Checks of a data frame header against a frame length.
  function automatic status_t data_checks(input logic [16:0] len,
                                          input logic [15:0] off,
                                          input logic [15:0] size);
    logic [17:0] need;
    logic [16:0] top_end;
    need    = 18'(DATA_HDR_LEN) + {2'b00, size};
    top_end = {1'b0, off} + {1'b0, size};
    if (len < DATA_HDR_LEN || need != {1'b0, len}) begin
      return ST_DATA_SIZE;
    end else if (top_end > 17'(STORE_BYTES)) begin
      return ST_OVER;
    end
    return ST_OK;
  endfunction

  // Payload write of a data frame.
  assign k_idx  = pos_r - DATA_HDR_LEN;
  assign wr_idx = {2'b00, h_off} + {1'b0, k_idx};
  assign wr_ok  = (pos_r >= DATA_HDR_LEN) && (hdr_cur[7:0] == HDR_VERSION) &&
                  (hdr_cur[15:8] == CMD_DATA) && (ferr_r == ST_OK) &&
                  (k_idx < {1'b0, h_size}) && (wr_idx < 18'(STORE_BYTES));

  // Verdict formed on the final byte of a frame.
  always_comb begin
    res_status  = ST_OK;
    res_action  = ACT_NONE;
    res_slot    = 8'd0;
    res_plen    = 16'd0;
    res_sweep   = 1'b0;
    res_run_crc = 1'b0;
    if (({1'b0, pos_r} + 18'd1) != {1'b0, in_len} || in_len < MIN_LEN) begin
      res_status = ST_SIZE;
    end else if (hdr_cur[7:0] != HDR_VERSION) begin
      res_status = ST_VERSION;
    end else begin
      case (hdr_cur[15:8])
        CMD_DATA: begin
          res_status = data_checks(in_len, h_off, h_size);
        end
        CMD_PROGRAM: begin
          if (in_len != PROG_LEN) begin
            res_status = ST_SIZE;
          end else begin
            res_plen = h_plen;
            res_slot = h_slot;
            if ({1'b0, h_plen} > 17'(STORE_BYTES)) begin
              res_status = ST_OVER;
            end else begin
              res_sweep = 1'b1;
              if (h_slot == 8'd0 || h_slot > slot_count_r) begin
                res_status = ST_BAD_SLOT;
              end else begin
                res_run_crc = 1'b1;
              end
            end
          end
        end
        CMD_REBOOT: begin
          res_action = ACT_REBOOT;
        end
        CMD_RESTART: begin
          res_action = ACT_RESTART;
        end
        default: begin
          res_status = ST_UNKNOWN;
        end
      endcase
    end
  end

  // Store port: the sweep owns it, otherwise payload writes.
  always_comb begin
    if (state_r == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_addr  = addr_r;
      mem_wdata = 8'h00;
    end else begin
      mem_we    = accept && wr_ok;
      mem_addr  = wr_idx[STORE_AW-1:0];
      mem_wdata = in_byte;
    end
  end

  assign crc_init = accept && in_tlast && res_run_crc;

  // A result is loaded either at the end of a checking sweep or directly on
  // the final byte of any frame that needs no CRC.
  assign out_load = (state_r == S_DONE) || (accept && in_tlast && !res_run_crc);

  bfr_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  bfr_crc u_crc (
    .clk  (clk),
    .init (crc_init),
    .en   (rd_use_r),
    .data (mem_rdata),
    .crc  (crc_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      addr_r       <= '0;
      pos_r        <= '0;
      hdr_r        <= '0;
      ferr_r       <= ST_OK;
      slot_count_r <= 8'd2;
      do_crc_r     <= 1'b0;
      rd_use_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        slot_count_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // Read data of this sweep address feeds the CRC on the next cycle.
      rd_use_r <= (state_r == S_SWEEP) && do_crc_r &&
                  ({{(16-STORE_AW){1'b0}}, addr_r} < plen_r);
      case (state_r)
        S_SWEEP: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == STORE_AW'(STORE_BYTES - 1)) begin
            state_r <= S_TAIL;
          end
        end
        S_TAIL: begin
          state_r <= do_crc_r ? S_DONE : S_IDLE;
        end
        S_DONE: begin
          out_status_r <= (crc_val == crc_ref_r) ? ST_OK : ST_CRC;
          out_action_r <= (crc_val == crc_ref_r) ? ACT_STORE : ACT_NONE;
          out_slot_r   <= slot_r;
          out_plen_r   <= plen_r;
          out_crc_r    <= crc_val;
          do_crc_r     <= 1'b0;
          state_r      <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            if (in_tlast) begin
              pos_r  <= '0;
              hdr_r  <= '0;
              ferr_r <= ST_OK;
              if (!res_run_crc) begin
                out_status_r <= res_status;
                out_action_r <= res_action;
                out_slot_r   <= res_slot;
                out_plen_r   <= res_plen;
                out_crc_r    <= 16'd0;
              end
              if (res_sweep) begin
                state_r   <= S_SWEEP;
                addr_r    <= '0;
                do_crc_r  <= res_run_crc;
                plen_r    <= res_plen;
                slot_r    <= res_slot;
                crc_ref_r <= h_crc;
              end
            end else begin
              if (pos_r == 17'd5) begin
                ferr_r <= data_checks(in_len, h_off, h_size);
              end
              hdr_r <= hdr_cur;
              if (pos_r != 17'h1FFFF) begin
                pos_r <= pos_r + 17'd1;
              end
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_crc_r, out_plen_r, out_slot_r,
                       out_action_r, out_status_r};

  // The input is only taken between sweeps.
  a_ready_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_IDLE))
    else $error("input ready outside idle");

  // Every sweep cycle writes a zero into the store.
  a_sweep_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (mem_we && mem_wdata == 8'h00))
    else $error("sweep cycle without a clearing write");

  // A request for action only ever comes with a clean status.
  a_action_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r != ACT_NONE) |-> (out_status_r == ST_OK))
    else $error("action reported with an error status");

  // A CRC verdict is only produced when a checking sweep has ended.
  a_crc_after_sweep : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> ($past(state_r) == S_TAIL && do_crc_r))
    else $error("CRC verdict without a checking sweep");

endmodule
